// ===== hw/rtl/bspd_pkg.sv =====
`timescale 1ns / 1ps

package bspd_pkg;

    // Field widths of one tick and one result
    localparam int unsigned KEY_W       = 2;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 3 * KEY_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVENT_GAP    = 8'd1;

    // Register values after reset
    localparam logic [CNT_W-1:0]  LONG_PRESS_TICKS_RST = 8'd20;
    localparam logic [TIME_W-1:0] MIN_EVENT_GAP_RST    = 32'd1000;

    // Outcome of one key on one tick
    typedef struct packed {
        logic short_press;
        logic long_hit;
        logic dropped;
    } t_key_evt;

endpackage

// ===== hw/rtl/bspd_key.sv =====
`timescale 1ns / 1ps

module bspd_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_level,
    input  logic [bspd_pkg::TIME_W-1:0]   i_now,
    input  logic [bspd_pkg::CNT_W-1:0]    i_long_ticks,
    input  logic [bspd_pkg::TIME_W-1:0]   i_min_gap,
    output bspd_pkg::t_key_evt            o_evt
);

    logic                        r_level;
    logic [bspd_pkg::CNT_W-1:0]  r_count;
    logic [bspd_pkg::TIME_W-1:0] r_time;

    logic                        n_level;
    logic [bspd_pkg::CNT_W-1:0]  n_count;
    logic [bspd_pkg::TIME_W-1:0] n_time;

    logic                        ev_short;
    logic                        ev_long;
    logic [bspd_pkg::TIME_W-1:0] diff;
    logic                        gap_ok;

    always_comb begin
        n_level  = i_level;
        n_count  = r_count;
        ev_short = 1'b0;
        ev_long  = 1'b0;
        if (i_level != r_level) begin
            if (!i_level) begin
                n_count = '0;
            end else if (r_count < i_long_ticks) begin
                ev_short = 1'b1;
            end
        end else if (!i_level && (r_count != bspd_pkg::CNT_MAX)) begin
            ev_long = (r_count == i_long_ticks);
            n_count = r_count + 1'b1;
        end
    end

    // Wrapping difference against the last accepted event
    assign diff   = i_now - r_time;
    assign gap_ok = (diff >= i_min_gap);
    assign n_time = ((ev_short || ev_long) && gap_ok) ? i_now : r_time;

    assign o_evt.short_press = ev_short && gap_ok;
    assign o_evt.long_hit    = ev_long && gap_ok;
    assign o_evt.dropped     = (ev_short || ev_long) && !gap_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_count <= '0;
            r_time  <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_count <= n_count;
            r_time  <= n_time;
        end
    end

endmodule

// ===== hw/rtl/button_short_long_press_detector_top.sv =====
`timescale 1ns / 1ps
// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tdata: key_levels, timestamp (+6 pad bits)
// m_axis    | out | m_axis_tvalid/tready    | tdata: short_mask, long_mask,
//           |     |                         |        dropped_mask (+2 pad bits)
// cfg       | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One tick per clock while the result side keeps up; a tick passes through the input register
// and then the result register, where its result beat is presented.
// The per-key compare, increment and 32-bit gap subtract sit between those two registers.
// Reset (i_rst_n low, synchronous) empties both stages, releases every key, clears hold
// counts and event times, and loads the register defaults.
// A stalled result beat holds the result register; the input register still takes a tick
// while it is empty, or while the result register is free or being emptied in the same cycle.
// Configuration writes are taken every cycle.

module button_short_long_press_detector_top #(
    parameter int unsigned KEY_COUNT = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Tick in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] key_levels, [33:2] timestamp, [39:34] zero
    input  logic [bspd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] short_mask, [3:2] long_mask, [5:4] dropped_mask, [7:6] zero
    output logic [bspd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bspd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bspd_pkg::TIME_W-1:0]         i_cfg_data
);

    localparam int unsigned KW = bspd_pkg::KEY_W;

    // Configuration registers
    logic [bspd_pkg::CNT_W-1:0]  r_long_ticks;
    logic [bspd_pkg::TIME_W-1:0] r_min_gap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= bspd_pkg::LONG_PRESS_TICKS_RST;
            r_min_gap    <= bspd_pkg::MIN_EVENT_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bspd_pkg::CFG_LONG_PRESS_TICKS: r_long_ticks <= i_cfg_data[bspd_pkg::CNT_W-1:0];
                bspd_pkg::CFG_MIN_EVENT_GAP:    r_min_gap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage control: the result register frees up when empty or being taken,
    // the input register advances into it whenever it does.
    logic r_in_valid;
    logic r_out_valid;
    logic out_adv;
    logic in_adv;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign in_adv        = r_in_valid && out_adv;
    assign s_axis_tready = !r_in_valid || out_adv;

    // Input register
    logic [KW-1:0]               r_in_levels;
    logic [bspd_pkg::TIME_W-1:0] r_in_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_levels <= s_axis_tdata[KW-1:0];
            r_in_time   <= s_axis_tdata[KW +: bspd_pkg::TIME_W];
        end
    end

    // One lane per key; keys past the level field stay pressed
    bspd_pkg::t_key_evt evt [KEY_COUNT];

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        logic lvl;
        if (k < KW) begin : g_in
            assign lvl = r_in_levels[k];
        end else begin : g_pressed
            assign lvl = 1'b0;
        end

        bspd_key u_key (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (in_adv),
            .i_level      (lvl),
            .i_now        (r_in_time),
            .i_long_ticks (r_long_ticks),
            .i_min_gap    (r_min_gap),
            .o_evt        (evt[k])
        );
    end

    // Gather the masks for the keys that have result bits
    logic [KW-1:0] short_m;
    logic [KW-1:0] long_m;
    logic [KW-1:0] drop_m;

    for (genvar k = 0; k < KW; k++) begin : g_mask
        if (k < KEY_COUNT) begin : g_used
            assign short_m[k] = evt[k].short_press;
            assign long_m[k]  = evt[k].long_hit;
            assign drop_m[k]  = evt[k].dropped;
        end else begin : g_absent
            assign short_m[k] = 1'b0;
            assign long_m[k]  = 1'b0;
            assign drop_m[k]  = 1'b0;
        end
    end

    // Result register
    logic [bspd_pkg::OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out_data <= {{bspd_pkg::OUT_PAD_W{1'b0}}, drop_m, long_m, short_m};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/bspd_chk.sv =====
`timescale 1ns / 1ps

module bspd_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bspd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int unsigned KW = bspd_pkg::KEY_W;

    logic [KW-1:0] short_m;
    logic [KW-1:0] long_m;
    logic [KW-1:0] drop_m;

    assign short_m = m_axis_tdata[KW-1:0];
    assign long_m  = m_axis_tdata[2*KW-1:KW];
    assign drop_m  = m_axis_tdata[3*KW-1:2*KW];

    // A key reports at most one kind of event per tick
    a_short_long_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((short_m & long_m) == '0))
        else $error("short and long press on the same key");

    a_drop_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((short_m | long_m) & drop_m) == '0))
        else $error("event both reported and dropped");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bspd_pkg::OUT_TDATA_W-1:3*KW] == '0))
        else $error("result pad bits not zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind button_short_long_press_detector_top bspd_chk u_bspd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/press_report_checker.sv =====
`timescale 1ns / 1ps

module press_report_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tick_valid,
    input  logic                              i_tick_ready,
    input  logic [bspd_pkg::IN_TDATA_W-1:0]   i_tick_data,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [bspd_pkg::OUT_TDATA_W-1:0]  i_res_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [bspd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bspd_pkg::TIME_W-1:0]       i_cfg_data,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_pending,
    output int unsigned                       o_results,
    output int unsigned                       o_short_seen,
    output int unsigned                       o_long_seen,
    output int unsigned                       o_drop_seen
);

    localparam int unsigned KW = bspd_pkg::KEY_W;
    localparam int unsigned TW = bspd_pkg::TIME_W;
    localparam int unsigned CW = bspd_pkg::CNT_W;
    localparam int unsigned OW = bspd_pkg::OUT_TDATA_W;

    typedef enum logic [1:0] {
        KEY_EV_NONE,
        KEY_EV_SHORT,
        KEY_EV_LONG
    } t_key_event;

    typedef struct packed {
        logic [KW-1:0] dropped;
        logic [KW-1:0] long_m;
        logic [KW-1:0] short_m;
    } t_press_report;

    // Shadow of the register file and the per-key tracking
    logic [CW-1:0]     long_ticks_q;
    logic [TW-1:0]     min_gap_q;
    logic              key_level_q [KW];
    logic [CW-1:0]     hold_cnt_q  [KW];
    logic [TW-1:0]     evt_time_q  [KW];

    t_press_report     pending_reports [$];
    int unsigned       fail_n;
    int unsigned       result_n;
    int unsigned       short_n;
    int unsigned       long_n;
    int unsigned       drop_n;

    function automatic t_press_report press_report(
        input logic [KW-1:0] levels,
        input logic [TW-1:0] now
    );
        t_press_report     rep;
        t_key_event        ev;
        logic [TW-1:0]     since;
        rep = '0;
        for (int k = 0; k < KW; k++) begin
            ev = KEY_EV_NONE;
            if (levels[k] != key_level_q[k]) begin
                if (!levels[k])
                    hold_cnt_q[k] = '0;
                else if (hold_cnt_q[k] < long_ticks_q)
                    ev = KEY_EV_SHORT;
                key_level_q[k] = levels[k];
            end else if (!levels[k] && hold_cnt_q[k] != bspd_pkg::CNT_MAX) begin
                if (hold_cnt_q[k] == long_ticks_q)
                    ev = KEY_EV_LONG;
                hold_cnt_q[k] = hold_cnt_q[k] + 1'b1;
            end
            if (ev != KEY_EV_NONE) begin
                since = now - evt_time_q[k];
                if (since < min_gap_q) begin
                    rep.dropped[k] = 1'b1;
                end else begin
                    evt_time_q[k] = now;
                    if (ev == KEY_EV_SHORT)
                        rep.short_m[k] = 1'b1;
                    else
                        rep.long_m[k] = 1'b1;
                end
            end
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_press_report want;
        if (!i_rst_n) begin
            long_ticks_q = bspd_pkg::LONG_PRESS_TICKS_RST;
            min_gap_q    = bspd_pkg::MIN_EVENT_GAP_RST;
            for (int k = 0; k < KW; k++) begin
                key_level_q[k] = 1'b1;
                hold_cnt_q[k]  = '0;
                evt_time_q[k]  = '0;
            end
            pending_reports.delete();
            fail_n   = 0;
            result_n = 0;
            short_n  = 0;
            long_n   = 0;
            drop_n   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bspd_pkg::CFG_LONG_PRESS_TICKS: long_ticks_q = i_cfg_data[CW-1:0];
                    bspd_pkg::CFG_MIN_EVENT_GAP:    min_gap_q    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                result_n++;
                if (pending_reports.size() == 0) begin
                    $error("result beat: expected none, actual %h", i_res_data);
                    fail_n++;
                end else begin
                    want = pending_reports.pop_front();
                    if (i_res_data[KW-1:0] !== want.short_m) begin
                        $error("short_mask: expected %b, actual %b",
                               want.short_m, i_res_data[KW-1:0]);
                        fail_n++;
                    end
                    if (i_res_data[2*KW-1:KW] !== want.long_m) begin
                        $error("long_mask: expected %b, actual %b",
                               want.long_m, i_res_data[2*KW-1:KW]);
                        fail_n++;
                    end
                    if (i_res_data[3*KW-1:2*KW] !== want.dropped) begin
                        $error("dropped_mask: expected %b, actual %b",
                               want.dropped, i_res_data[3*KW-1:2*KW]);
                        fail_n++;
                    end
                    if (i_res_data[OW-1:3*KW] !== '0) begin
                        $error("pad: expected %b, actual %b",
                               {bspd_pkg::OUT_PAD_W{1'b0}}, i_res_data[OW-1:3*KW]);
                        fail_n++;
                    end
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                want = press_report(i_tick_data[KW-1:0], i_tick_data[KW +: TW]);
                short_n += $countones(want.short_m);
                long_n  += $countones(want.long_m);
                drop_n  += $countones(want.dropped);
                pending_reports.push_back(want);
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= pending_reports.size();
        o_results    <= result_n;
        o_short_seen <= short_n;
        o_long_seen  <= long_n;
        o_drop_seen  <= drop_n;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned KW               = bspd_pkg::KEY_W;
    localparam int unsigned TW               = bspd_pkg::TIME_W;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_TICKS      = 265;
    localparam int unsigned PHASE_COUNT      = 6;
    // Two register stages inside the block, plus some margin
    localparam int unsigned DRAIN_CYCLES     = 6;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // [1:0] key_levels, [33:2] timestamp, [39:34] zero
    logic [bspd_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // [1:0] short_mask, [3:2] long_mask, [5:4] dropped_mask, [7:6] zero
    logic [bspd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [bspd_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [TW-1:0]                       i_cfg_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results;
    int unsigned short_seen;
    int unsigned long_seen;
    int unsigned drop_seen;

    // Stimulus shaping
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       cur_thr;
    longint unsigned   cur_gap;
    logic [TW-1:0]     now_q;
    logic              plan_level [KW];
    int unsigned       run_left   [KW];
    int unsigned       ticks_sent;
    int unsigned       settings_n;
    int unsigned       cycle_count;

    // Long receiver hold-off: the top bumps the request, the receiver counts
    int unsigned       hold_req_seq;
    int unsigned       hold_seen_seq;
    int unsigned       hold_left;

    button_short_long_press_detector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    press_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_short_seen (short_seen),
        .o_long_seen  (long_seen),
        .o_drop_seen  (drop_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Give up well beyond the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls per phase, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen_seq != hold_req_seq) begin
            hold_seen_seq <= hold_req_seq;
            hold_left     <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one tick beat, idling first at the phase's rate; return once taken
    task automatic send_tick(input logic [KW-1:0] levels, input logic [TW-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bspd_pkg::IN_TDATA_W - KW - TW){1'b0}}, now, levels};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // Drop valid and hold until every result is back and the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bspd_pkg::CFG_IDX_W-1:0] index,
                             input logic [TW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only ever called with the block idle
    task automatic apply_setting(input int unsigned thr, input longint unsigned gap);
        wait_drained();
        write_reg(bspd_pkg::CFG_LONG_PRESS_TICKS, thr);
        write_reg(bspd_pkg::CFG_MIN_EVENT_GAP, gap[TW-1:0]);
        cur_thr = thr;
        cur_gap = gap;
        settings_n++;
    endtask

    // Press lengths cluster around the threshold so both edges of it get hit;
    // a few runs go past the counter's ceiling
    function automatic int unsigned pressed_len();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return $urandom_range(1, cur_thr + 1);
        else if (pick < 75)
            return (cur_thr == 0) ? $urandom_range(1, 3) : cur_thr + $urandom_range(0, 3);
        else if (pick < 96)
            return cur_thr + $urandom_range(2, 30);
        else
            return $urandom_range(250, 270);
    endfunction

    // Walk each key through press/hold/release runs; mix in raw noise ticks
    task automatic next_levels(output logic [KW-1:0] levels);
        int unsigned noise;
        for (int k = 0; k < KW; k++) begin
            if (run_left[k] == 0) begin
                plan_level[k] = ~plan_level[k];
                run_left[k]   = plan_level[k] ? $urandom_range(1, 6) : pressed_len();
            end
            levels[k] = plan_level[k];
            run_left[k]--;
        end
        if ($urandom_range(99) < 8) begin
            noise  = $urandom_range(3);
            levels = noise[KW-1:0];
        end
    endtask

    // Advance the timestamp so that event spacing lands on both sides of the gap
    task automatic next_time();
        longint unsigned span;
        span = (2 * cur_gap) / (cur_thr + 4) + 2;
        if ($urandom_range(99) < 4 || span > 64'hFFFF_FFFF)
            now_q = $urandom();
        else
            now_q = now_q + $urandom_range(0, span[31:0]);
    endtask

    task automatic run_phase(input int unsigned ticks, input bit with_pressure);
        logic [KW-1:0] levels;
        for (int unsigned n = 0; n < ticks; n++) begin
            if (with_pressure && n == ticks / 3)
                hold_req_seq++;
            next_levels(levels);
            next_time();
            send_tick(levels, now_q);
        end
    endtask

    initial begin
        int unsigned thr;
        longint unsigned gap;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_thr        = bspd_pkg::LONG_PRESS_TICKS_RST;
        cur_gap        = bspd_pkg::MIN_EVENT_GAP_RST;
        now_q          = '0;
        ticks_sent     = 0;
        settings_n     = 0;
        cycle_count    = 0;
        hold_req_seq   = 0;
        hold_seen_seq  = 0;
        hold_left      = 0;
        for (int k = 0; k < KW; k++) begin
            plan_level[k] = 1'b1;
            run_left[k]   = 1;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tiny threshold and gap so each event kind shows up quickly
        apply_setting(2, 5);
        send_tick(2'b11, 32'h0000_0000);
        send_tick(2'b10, 32'h0000_0001);    // key 0 down straight after reset
        send_tick(2'b11, 32'h0000_0002);    // short, too close to event time zero
        send_tick(2'b01, 32'h0000_000A);    // key 1 down
        send_tick(2'b01, 32'h0000_000B);
        send_tick(2'b01, 32'h0000_000C);
        send_tick(2'b01, 32'h0000_000D);    // long fires here
        send_tick(2'b11, 32'h0000_000E);    // release after long: nothing
        send_tick(2'b00, 32'hFFFF_FFF0);    // both keys down together
        send_tick(2'b11, 32'hFFFF_FFFF);    // both short, top of the timer
        send_tick(2'b00, 32'h0000_0002);
        send_tick(2'b11, 32'h0000_0003);    // gap across the wrap too small: dropped
        send_tick(2'b00, 32'h0000_0008);
        send_tick(2'b11, 32'h0000_0009);    // wrapped gap wide enough: accepted

        // Zero threshold and zero gap
        apply_setting(0, 0);
        send_tick(2'b10, 32'h0000_0064);
        send_tick(2'b11, 32'h0000_0065);    // released before any held tick
        send_tick(2'b10, 32'h0000_0066);
        send_tick(2'b10, 32'h0000_0066);    // first held tick: long, same timestamp
        send_tick(2'b10, 32'h0000_0067);
        send_tick(2'b11, 32'h0000_0068);

        // Widest gap: only a difference of all ones could pass
        apply_setting(254, 64'hFFFF_FFFF);
        send_tick(2'b01, 32'h5555_5555);
        send_tick(2'b11, 32'hAAAA_AAAA);    // short, dropped

        // Random phases, each with its own register setting and idling mix
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    thr = bspd_pkg::LONG_PRESS_TICKS_RST;
                    gap = bspd_pkg::MIN_EVENT_GAP_RST;
                end
                1: begin thr = 1;   gap = 0; end
                2: begin thr = 0;   gap = 37; end
                3: begin thr = 255; gap = 0; end
                4: begin thr = $urandom_range(2, 40); gap = $urandom_range(1, 5000); end
                default: begin thr = 254; gap = 64'hFFFF_FFFF; end
            endcase
            apply_setting(thr, gap);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // Hold the result side off in the unthrottled phase so the block backs up
            run_phase(PHASE_TICKS, p == 0);
        end

        wait_drained();

        $display("ran %0d ticks through %0d register settings, %0d result beats checked",
                 ticks_sent, settings_n, results);
        $display("reported: %0d short, %0d long, %0d dropped", short_seen, long_seen,
                 drop_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
